/* hw/rtl/bank_mapper_with_irq_counter_core_assert.svh */
// ----------------------------------------------------------------------------
// bank_mapper_with_irq_counter_core_assert
// Assertion macros for the bank mapper core. Both macros sample on clk and
// are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BANK_MAPPER_WITH_IRQ_COUNTER_CORE_ASSERT_SVH
`define BANK_MAPPER_WITH_IRQ_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BMIC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BMIC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bmic_pkg.sv */
// ----------------------------------------------------------------------------
// bmic_pkg
// Shared types, constants and helper functions of the bank mapper core.
// ----------------------------------------------------------------------------
`default_nettype none

package bmic_pkg;

	localparam int RAM_DEPTH     = 8192;
	localparam int RAM_AW        = $clog2(RAM_DEPTH);
	localparam int PRG_BANK_BITS = 6;
	localparam int CHR_BANK_BITS = 8;
	localparam int PRG_WINDOWS   = 4;
	localparam int CHR_WINDOWS   = 8;
	localparam int MAP_AW        = 19;
	localparam int CFG_W         = 6;

	localparam logic [2:0] OP_CPU_READ  = 3'd0;
	localparam logic [2:0] OP_CPU_WRITE = 3'd1;
	localparam logic [2:0] OP_PPU_READ  = 3'd2;
	localparam logic [2:0] OP_TICK      = 3'd3;
	localparam logic [2:0] OP_IRQ_ACK   = 3'd4;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ROM  = 2'd1;
	localparam logic [1:0] KIND_RAM  = 2'd2;

	localparam logic [2:0] MIRROR_DEFAULT = 3'd4;
	localparam logic [CFG_W-1:0] RESET_16K_BANKS = 6'd2;

	typedef logic [PRG_BANK_BITS-1:0] prg_bank_t;
	typedef logic [CHR_BANK_BITS-1:0] chr_bank_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] addr;
		logic [7:0]  data;
	} item_t;

	function automatic prg_bank_t last_bank(input logic [CFG_W-1:0] n16k);
		logic [CFG_W:0] n8k;
		n8k = {n16k, 1'b0} - {{CFG_W{1'b0}}, 1'b1};
		return n8k[PRG_BANK_BITS-1:0];
	endfunction

	function automatic logic [15:0] size_mask(input logic [1:0] sel);
		logic [15:0] m;
		case (sel)
			2'd0: m = 16'hFFFF;
			2'd1: m = 16'h0FFF;
			2'd2: m = 16'h00FF;
			2'd3: m = 16'h000F;
			default: m = 16'hFFFF;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/bank_mapper_with_irq_counter_core.sv */
// ----------------------------------------------------------------------------
// bank_mapper_with_irq_counter_core
// Flow: an accepted item is registered in the stage, then its result in the output register.
// Throughput: one item per cycle; input stalls only while the stage and a stalled result wait.
// Reset: banks but the last PRG bank, IRQ state and handshake clear at once; work RAM is not.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bank_mapper_with_irq_counter_core_assert.svh"

module bank_mapper_with_irq_counter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [5:0]  cfg_write_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  hit_kind,
	output logic [18:0] mapped_address,
	output logic [7:0]  read_data,
	output logic        irq_level,
	output logic [2:0]  mirror_mode
);

	localparam logic [15:0] ADDR_RAM_EN     = 16'h9002;
	localparam logic [15:0] ADDR_IRQ_LOAD   = 16'hF000;
	localparam logic [15:0] ADDR_IRQ_CTRL   = 16'hF001;
	localparam logic [15:0] ADDR_MIRROR     = 16'hF002;

	logic                 s1_valid_q;
	bmic_pkg::item_t      item_s1;
	logic                 adv;
	logic                 take;

	bmic_pkg::prg_bank_t  prg_bank_q [bmic_pkg::PRG_WINDOWS];
	bmic_pkg::chr_bank_t  chr_bank_q [bmic_pkg::CHR_WINDOWS];
	logic                 ram_enable_q;
	logic [15:0]          irq_reload_q;
	logic [15:0]          irq_count_q;
	logic                 irq_on_q;
	logic [1:0]           irq_size_q;
	logic                 irq_pending_q;
	logic [2:0]           mirror_q;

	bmic_pkg::prg_bank_t  prg_nxt [bmic_pkg::PRG_WINDOWS];
	bmic_pkg::chr_bank_t  chr_nxt [bmic_pkg::CHR_WINDOWS];
	logic                 ram_en_nxt;
	logic [15:0]          reload_nxt;
	logic [15:0]          count_nxt;
	logic                 on_nxt;
	logic [1:0]           size_nxt;
	logic                 pend_nxt;
	logic [2:0]           mirror_nxt;
	logic [1:0]           kind;
	logic [18:0]          maddr;
	logic                 ram_we;
	logic                 ram_re;

	logic [7:0]           work_ram_q [bmic_pkg::RAM_DEPTH];
	logic [bmic_pkg::RAM_AW-1:0] ram_idx;

	logic                 result_valid_q;
	logic [1:0]           hit_kind_q;
	logic [18:0]          mapped_q;
	logic [7:0]           rdata_q;

	assign adv        = s1_valid_q && (!result_valid_q || !result_stall);
	assign item_stall = s1_valid_q && !adv;
	assign take       = item_valid && !item_stall;
	assign ram_idx    = item_s1.addr[bmic_pkg::RAM_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op   <= opcode;
			item_s1.addr <= address;
			item_s1.data <= write_data;
		end
	end

	always_comb begin
		logic [15:0] a;
		logic [7:0]  d;
		logic        in_ram;
		logic        prg_hit;
		logic        chr_hit;
		logic [1:0]  pi;
		logic [2:0]  ci;
		logic [5:0]  p6;
		logic [7:0]  c8;
		logic [15:0] dec;
		a          = item_s1.addr;
		d          = item_s1.data;
		in_ram     = (a[15:13] == 3'b011) && ram_enable_q;
		prg_hit    = ((a[15:12] == 4'h8) || ((a[15:12] == 4'h9) && !a[1]))
			&& (a[11:2] == 10'd0);
		chr_hit    = (a[15:12] >= 4'hA) && (a[15:12] <= 4'hD) && (a[11:2] == 10'd0);
		pi         = a[12] ? 2'd2 : {1'b0, a[1]};
		ci         = {a[13:12] - 2'd2, a[1]};
		p6         = 6'(prg_bank_q[pi]);
		c8         = 8'(chr_bank_q[ci]);
		dec        = irq_on_q ? (irq_count_q - 16'd1) : irq_count_q;
		prg_nxt    = prg_bank_q;
		chr_nxt    = chr_bank_q;
		ram_en_nxt = ram_enable_q;
		reload_nxt = irq_reload_q;
		count_nxt  = irq_count_q;
		on_nxt     = irq_on_q;
		size_nxt   = irq_size_q;
		pend_nxt   = irq_pending_q;
		mirror_nxt = mirror_q;
		kind       = bmic_pkg::KIND_NONE;
		maddr      = '0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		case (item_s1.op)
			bmic_pkg::OP_CPU_READ: begin
				if (in_ram) begin
					kind   = bmic_pkg::KIND_RAM;
					ram_re = 1'b1;
				end else if (a[15]) begin
					kind  = bmic_pkg::KIND_ROM;
					maddr = (19'(prg_bank_q[a[14:13]]) << 13) | 19'(a[12:0]);
				end
			end
			bmic_pkg::OP_CPU_WRITE: begin
				if (in_ram) begin
					kind   = bmic_pkg::KIND_RAM;
					ram_we = 1'b1;
				end else if (prg_hit) begin
					if (!a[0]) begin
						p6[3:0] = d[3:0];
					end else begin
						p6[5:4] = d[1:0];
					end
					prg_nxt[pi] = p6[bmic_pkg::PRG_BANK_BITS-1:0];
				end else if (a == ADDR_RAM_EN) begin
					ram_en_nxt = d[1];
				end else if (chr_hit) begin
					if (!a[0]) begin
						c8[3:0] = d[3:0];
					end else begin
						c8[7:4] = d[3:0];
					end
					chr_nxt[ci] = c8[bmic_pkg::CHR_BANK_BITS-1:0];
				end else if (a[15:12] == 4'hE) begin
					reload_nxt[{a[1:0], 2'b00} +: 4] = d[3:0];
				end else if (a == ADDR_IRQ_LOAD) begin
					count_nxt = irq_reload_q;
					pend_nxt  = 1'b0;
				end else if (a == ADDR_IRQ_CTRL) begin
					on_nxt   = d[0];
					size_nxt = d[3] ? 2'd3 : (d[2] ? 2'd2 : (d[1] ? 2'd1 : 2'd0));
					pend_nxt = 1'b0;
				end else if (a == ADDR_MIRROR) begin
					mirror_nxt = {1'b0, d[1:0]};
				end
			end
			bmic_pkg::OP_PPU_READ: begin
				if (a[15:13] == 3'b000) begin
					kind  = bmic_pkg::KIND_ROM;
					maddr = (19'(chr_bank_q[a[12:10]]) << 10) | 19'(a[9:0]);
				end
			end
			bmic_pkg::OP_TICK: begin
				if (irq_count_q == 16'd0) begin
					count_nxt = irq_reload_q & bmic_pkg::size_mask(irq_size_q);
				end else begin
					count_nxt = dec;
					if (dec == 16'd0) begin
						pend_nxt = 1'b1;
					end
				end
			end
			bmic_pkg::OP_IRQ_ACK: begin
				pend_nxt = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bmic_pkg::PRG_WINDOWS - 1; i++) begin
				prg_bank_q[i] <= '0;
			end
			prg_bank_q[bmic_pkg::PRG_WINDOWS-1] <=
				bmic_pkg::last_bank(bmic_pkg::RESET_16K_BANKS);
			for (int i = 0; i < bmic_pkg::CHR_WINDOWS; i++) begin
				chr_bank_q[i] <= '0;
			end
			ram_enable_q  <= 1'b0;
			irq_reload_q  <= '0;
			irq_count_q   <= '0;
			irq_on_q      <= 1'b0;
			irq_size_q    <= '0;
			irq_pending_q <= 1'b0;
			mirror_q      <= bmic_pkg::MIRROR_DEFAULT;
		end else if (cfg_write_en) begin
			prg_bank_q[bmic_pkg::PRG_WINDOWS-1] <= bmic_pkg::last_bank(cfg_write_data);
		end else if (adv) begin
			prg_bank_q    <= prg_nxt;
			chr_bank_q    <= chr_nxt;
			ram_enable_q  <= ram_en_nxt;
			irq_reload_q  <= reload_nxt;
			irq_count_q   <= count_nxt;
			irq_on_q      <= on_nxt;
			irq_size_q    <= size_nxt;
			irq_pending_q <= pend_nxt;
			mirror_q      <= mirror_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ram_we) begin
			work_ram_q[ram_idx] <= item_s1.data;
		end
		if (adv) begin
			rdata_q <= ram_re ? work_ram_q[ram_idx] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_kind_q <= kind;
			mapped_q   <= maddr;
		end
	end

	assign result_valid   = result_valid_q;
	assign hit_kind       = hit_kind_q;
	assign mapped_address = mapped_q;
	assign read_data      = rdata_q;
	assign irq_level      = irq_pending_q;
	assign mirror_mode    = mirror_q;

	`BMIC_ASSERT_IMP(a_stall_has_item, item_stall, s1_valid_q,
		"input stalled with an empty stage")
	`BMIC_ASSERT_NXT(a_ack_clears_irq, adv && (item_s1.op == bmic_pkg::OP_IRQ_ACK),
		!irq_pending_q, "IRQ still pending after acknowledge")
	`BMIC_ASSERT_NXT(a_ram_gated, adv && !ram_enable_q,
		hit_kind_q != bmic_pkg::KIND_RAM, "RAM hit while RAM disabled")
	`BMIC_ASSERT_IMP(a_addr_only_rom, result_valid_q && (hit_kind_q != bmic_pkg::KIND_ROM),
		mapped_q == 19'd0, "mapped address set on a non-ROM result")

endmodule

`default_nettype wire

/* dv/bank_mapper_with_irq_counter_core_tb.sv */
// ----------------------------------------------------------------------------
// bank_mapper_with_irq_counter_core_tb
// Self-checking testbench for the bank mapper core. A short directed run
// covers reset state, bank registers, work RAM and the IRQ counter. Random
// traffic under several idle and stall patterns follows, and the ROM size
// register changes between phases. Each result transfer is checked in order
// against a built-in model of the mapper.
// ----------------------------------------------------------------------------
module bank_mapper_with_irq_counter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bmic_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 6;

	localparam logic [2:0] OP_UNUSED = 3'd7;

	localparam logic [15:0] WIN_RAM        = 16'h6000;
	localparam logic [15:0] REG_PRG0_LO    = 16'h8000;
	localparam logic [15:0] REG_PRG0_HI    = 16'h8001;
	localparam logic [15:0] REG_PRG2_LO    = 16'h9000;
	localparam logic [15:0] REG_PRG2_HI    = 16'h9001;
	localparam logic [15:0] REG_RAM_EN     = 16'h9002;
	localparam logic [15:0] REG_CHR0_LO    = 16'hA000;
	localparam logic [15:0] REG_CHR7_LO    = 16'hD002;
	localparam logic [15:0] REG_CHR7_HI    = 16'hD003;
	localparam logic [15:0] REG_IRQ_LATCH  = 16'hE000;
	localparam logic [15:0] REG_IRQ_RELOAD = 16'hF000;
	localparam logic [15:0] REG_IRQ_CTRL   = 16'hF001;
	localparam logic [15:0] REG_MIRROR     = 16'hF002;

	typedef struct packed {
		logic [1:0]  kind;
		logic [18:0] addr;
		logic [7:0]  data;
		logic        irq;
		logic [2:0]  mirror;
	} mapper_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [5:0]  cfg_write_data = 6'd0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [2:0]  opcode = 3'd0;
	logic [15:0] address = 16'd0;
	logic [7:0]  write_data = 8'd0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  hit_kind;
	logic [18:0] mapped_address;
	logic [7:0]  read_data;
	logic        irq_level;
	logic [2:0]  mirror_mode;

	int src_idle_pct = 0;
	int rcv_stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;

	prg_bank_t   prg_window_bank [PRG_WINDOWS];
	chr_bank_t   chr_window_bank [CHR_WINDOWS];
	logic [7:0]  wram_copy [RAM_DEPTH];
	bit          wram_written [RAM_DEPTH];
	logic [12:0] wram_filled [$];
	logic        wram_on;
	logic [15:0] model_reload;
	logic [15:0] model_count;
	logic        irq_running;
	logic [1:0]  irq_width_sel;
	logic        irq_flag;
	logic [2:0]  mirror_sel_q;

	mapper_result_t mapper_responses_due [$];

	bank_mapper_with_irq_counter_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.opcode         (opcode),
		.address        (address),
		.write_data     (write_data),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.hit_kind       (hit_kind),
		.mapped_address (mapped_address),
		.read_data      (read_data),
		.irq_level      (irq_level),
		.mirror_mode    (mirror_mode)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("bank_mapper_with_irq_counter_core verification failed");
			$finish;
		end
	end

	function automatic mapper_result_t map_access(input logic [2:0] op, input logic [15:0] a,
			input logic [7:0] d);
		mapper_result_t r;
		logic ram_hit;
		logic [3:0] lo;
		logic [3:0] grp;
		logic [1:0] pidx;
		logic [2:0] cidx;
		r = '0;
		lo = d[3:0];
		ram_hit = wram_on && (a[15:13] == WIN_RAM[15:13]);
		case (op)
			OP_CPU_READ: begin
				if (ram_hit) begin
					r.kind = KIND_RAM;
					r.data = wram_copy[a[12:0]];
				end else if (a[15]) begin
					r.kind = KIND_ROM;
					r.addr = {prg_window_bank[a[14:13]], a[12:0]};
				end
			end
			OP_CPU_WRITE: begin
				if (ram_hit) begin
					r.kind = KIND_RAM;
					wram_copy[a[12:0]] = d;
					if (!wram_written[a[12:0]]) begin
						wram_written[a[12:0]] = 1'b1;
						wram_filled.push_back(a[12:0]);
					end
				end else if ((a & ~16'h0003) == REG_PRG0_LO || a == REG_PRG2_LO
						|| a == REG_PRG2_HI) begin
					pidx = (a[15:12] == REG_PRG2_LO[15:12]) ? 2'd2 : {1'b0, a[1]};
					if (!a[0])
						prg_window_bank[pidx][3:0] = lo;
					else
						prg_window_bank[pidx][5:4] = d[1:0];
				end else if (a == REG_RAM_EN) begin
					wram_on = d[1];
				end else if (a[15:12] >= REG_CHR0_LO[15:12] && a[15:12] <= REG_CHR7_LO[15:12]
						&& a[11:2] == 10'd0) begin
					grp = a[15:12] - REG_CHR0_LO[15:12];
					cidx = {grp[1:0], a[1]};
					if (!a[0])
						chr_window_bank[cidx][3:0] = lo;
					else
						chr_window_bank[cidx][7:4] = lo;
				end else if (a[15:12] == REG_IRQ_LATCH[15:12]) begin
					model_reload[{a[1:0], 2'b00} +: 4] = lo;
				end else if (a == REG_IRQ_RELOAD) begin
					model_count = model_reload;
					irq_flag = 1'b0;
				end else if (a == REG_IRQ_CTRL) begin
					irq_running = lo[0];
					irq_width_sel = lo[3] ? 2'd3 : lo[2] ? 2'd2 : lo[1] ? 2'd1 : 2'd0;
					irq_flag = 1'b0;
				end else if (a == REG_MIRROR) begin
					mirror_sel_q = {1'b0, d[1:0]};
				end
			end
			OP_PPU_READ: begin
				if (a[15:13] == 3'b000) begin
					r.kind = KIND_ROM;
					r.addr = {1'b0, chr_window_bank[a[12:10]], a[9:0]};
				end
			end
			OP_TICK: begin
				if (model_count == 16'd0) begin
					model_count = model_reload & (16'hFFFF >> {irq_width_sel, 2'b00});
				end else begin
					if (irq_running)
						model_count = model_count - 16'd1;
					if (model_count == 16'd0)
						irq_flag = 1'b1;
				end
			end
			OP_IRQ_ACK: begin
				irq_flag = 1'b0;
			end
			default: begin
			end
		endcase
		r.irq = irq_flag;
		r.mirror = mirror_sel_q;
		return r;
	endfunction

	task automatic issue_access(input logic [2:0] op, input logic [15:0] a, input logic [7:0] d);
		int gap;
		logic [15:0] addr;
		addr = a;
		// Reads of work RAM go only to entries that hold a written byte.
		if (op == OP_CPU_READ && wram_on && addr[15:13] == WIN_RAM[15:13]
				&& !wram_written[addr[12:0]]) begin
			if (wram_filled.size() > 0)
				addr[12:0] = wram_filled[$urandom_range(wram_filled.size() - 1)];
			else
				addr[15] = 1'b1;
		end
		gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		address <= addr;
		write_data <= d;
		do @(posedge clk); while (item_stall);
		mapper_responses_due.push_back(map_access(op, addr, d));
	endtask

	task automatic settle_idle();
		item_valid <= 1'b0;
		while (mapper_responses_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_rom_size(input logic [5:0] n16k);
		settle_idle();
		cfg_write_en <= 1'b1;
		cfg_write_data <= n16k;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		prg_window_bank[3] = {n16k[4:0], 1'b0} - 6'd1;
	endtask

	always @(posedge clk) begin : result_check
		mapper_result_t seen;
		mapper_result_t want;
		seen = {hit_kind, mapped_address, read_data, irq_level, mirror_mode};
		if (arst_n && result_valid && !result_stall) begin
			if (mapper_responses_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected transfer: kind %0d addr %05h data %02h irq %0b mirror %0d",
						seen.kind, seen.addr, seen.data, seen.irq, seen.mirror);
			end else begin
				want = mapper_responses_due.pop_front();
				if (seen.kind !== want.kind || seen.addr !== want.addr || seen.data !== want.data
						|| seen.irq !== want.irq || seen.mirror !== want.mirror) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected kind %0d addr %05h data %02h irq %0b mirror %0d,",
							" got kind %0d addr %05h data %02h irq %0b mirror %0d"},
							want.kind, want.addr, want.data, want.irq, want.mirror,
							seen.kind, seen.addr, seen.data, seen.irq, seen.mirror);
				end
			end
		end
		result_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	task automatic test_reset_state();
		issue_access(OP_CPU_READ, 16'hFFFF, 8'h00);
		issue_access(OP_CPU_READ, REG_PRG0_LO, 8'h00);
		issue_access(OP_CPU_READ, WIN_RAM - 16'd1, 8'h00);
	endtask

	task automatic test_bank_registers();
		issue_access(OP_CPU_WRITE, REG_PRG0_LO, 8'hFF);
		issue_access(OP_CPU_WRITE, REG_PRG0_HI, 8'hFF);
		issue_access(OP_CPU_READ, 16'h9FFF, 8'h00);
		issue_access(OP_CPU_WRITE, REG_CHR7_LO, 8'h0F);
		issue_access(OP_CPU_WRITE, REG_CHR7_HI, 8'h0F);
		issue_access(OP_PPU_READ, 16'h1FFF, 8'h00);
		issue_access(OP_PPU_READ, 16'h2000, 8'h00);
	endtask

	task automatic test_work_ram();
		issue_access(OP_CPU_WRITE, WIN_RAM | 16'h1FFF, 8'hAA);
		issue_access(OP_CPU_WRITE, REG_RAM_EN, 8'h02);
		issue_access(OP_CPU_WRITE, WIN_RAM, 8'h00);
		issue_access(OP_CPU_WRITE, WIN_RAM | 16'h1FFF, 8'hFF);
		issue_access(OP_CPU_READ, WIN_RAM | 16'h1FFF, 8'h00);
		issue_access(OP_CPU_READ, WIN_RAM, 8'h00);
	endtask

	task automatic test_irq_counter();
		issue_access(OP_CPU_WRITE, REG_IRQ_LATCH, 8'h02);
		issue_access(OP_CPU_WRITE, REG_IRQ_LATCH | 16'd3, 8'h0F);
		issue_access(OP_CPU_WRITE, REG_IRQ_CTRL, 8'h09);
		repeat (3) issue_access(OP_TICK, 16'h0000, 8'h00);
		issue_access(OP_IRQ_ACK, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_misc_ops();
		issue_access(OP_CPU_WRITE, REG_MIRROR, 8'h03);
		issue_access(OP_UNUSED, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_random_traffic(input int count);
		int sent;
		int pick;
		int n;
		int ticks;
		int r;
		logic [15:0] a;
		logic [7:0] d;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			d = 8'($urandom_range(255));
			if (pick < 7) begin
				issue_access(OP_CPU_WRITE, REG_IRQ_LATCH, d);
				for (n = 1; n < 4; n++)
					issue_access(OP_CPU_WRITE, REG_IRQ_LATCH | 16'(n),
						($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00);
				issue_access(OP_CPU_WRITE, REG_IRQ_CTRL,
					8'($urandom_range(255)) | 8'($urandom_range(3) != 0));
				if ($urandom_range(1) == 1)
					issue_access(OP_CPU_WRITE, REG_IRQ_RELOAD, 8'($urandom_range(255)));
				ticks = $urandom_range(4, 40);
				for (n = 0; n < ticks; n++) begin
					if ($urandom_range(9) == 0)
						issue_access(OP_IRQ_ACK, 16'($urandom), 8'($urandom));
					else
						issue_access(OP_TICK, 16'($urandom), 8'($urandom));
				end
				sent += 6 + ticks;
			end else begin
				if (pick < 29) begin
					case ($urandom_range(5))
						0: begin
							r = $urandom_range(5);
							a = (r < 4) ? REG_PRG0_LO | 16'(r) : REG_PRG2_LO | 16'(r - 4);
						end
						1: begin
							a = REG_RAM_EN;
							d[1] = ($urandom_range(3) != 0);
						end
						2: a = REG_CHR0_LO + 16'($urandom_range(3)) * 16'h1000
							+ 16'($urandom_range(3));
						3: a = REG_IRQ_LATCH | 16'($urandom_range(16'h0FFF));
						4: a = REG_IRQ_RELOAD + 16'($urandom_range(2));
						default: a = 16'($urandom);
					endcase
					issue_access(OP_CPU_WRITE, a, d);
				end else if (pick < 43) begin
					issue_access(OP_CPU_READ, 16'h8000 | 16'($urandom), d);
				end else if (pick < 53) begin
					issue_access(OP_PPU_READ, 16'($urandom_range(16'h1FFF)), d);
				end else if (pick < 56) begin
					issue_access(OP_PPU_READ, 16'($urandom), d);
				end else if (pick < 66) begin
					issue_access(OP_CPU_WRITE, WIN_RAM | 16'($urandom_range(16'h1FFF)), d);
				end else if (pick < 76) begin
					issue_access(OP_CPU_READ, WIN_RAM | 16'($urandom_range(16'h1FFF)), d);
				end else if (pick < 90) begin
					issue_access(OP_TICK, 16'($urandom), d);
				end else if (pick < 93) begin
					issue_access(OP_IRQ_ACK, 16'($urandom), d);
				end else begin
					issue_access(3'($urandom_range(7)), 16'($urandom), d);
				end
				sent++;
			end
		end
	endtask

	initial begin
		foreach (prg_window_bank[i])
			prg_window_bank[i] = '0;
		foreach (chr_window_bank[i])
			chr_window_bank[i] = '0;
		prg_window_bank[3] = {RESET_16K_BANKS[4:0], 1'b0} - 6'd1;
		wram_on = 1'b0;
		model_reload = 16'd0;
		model_count = 16'd0;
		irq_running = 1'b0;
		irq_width_sel = 2'd0;
		irq_flag = 1'b0;
		mirror_sel_q = MIRROR_DEFAULT;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		set_rom_size(6'd32);
		test_bank_registers();
		test_work_ram();
		test_irq_counter();
		test_misc_ops();

		set_rom_size(6'd1);
		test_random_traffic(325);

		set_rom_size(6'($urandom_range(2, 31)));
		src_idle_pct = 55;
		test_random_traffic(325);

		set_rom_size(6'd32);
		src_idle_pct = 0;
		rcv_stall_pct = 55;
		test_random_traffic(325);

		set_rom_size(6'($urandom_range(1, 32)));
		src_idle_pct = 34;
		rcv_stall_pct = 34;
		test_random_traffic(325);

		settle_idle();
		if (mismatches == 0)
			$display("bank_mapper_with_irq_counter_core verification clean");
		else
			$display("bank_mapper_with_irq_counter_core verification failed");
		$finish;
	end

endmodule

/* bank_mapper_with_irq_counter_core.f */
+incdir+hw/rtl
hw/rtl/bmic_pkg.sv
hw/rtl/bank_mapper_with_irq_counter_core.sv
dv/bank_mapper_with_irq_counter_core_tb.sv
